// File: hdl/pcc_pkg.sv
// Shared types, constants and AES helper functions for the payload CTR cipher.
// No dependencies.
package pcc_pkg;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
    localparam int AES_ROUNDS      = 10;

    localparam logic [7:0] CTR_TAG  = 8'h01;
    localparam logic [7:0] RCON_ONE = 8'h01;

    typedef enum logic {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [3:0]  pos;
        logic [7:0]  cnt;
        logic        frm_start;
        logic        blk_start;
        logic [31:0] addr;
        logic        dir;
        logic [31:0] fcnt;
    } t_item;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// File: hdl/pcc_fifo.sv
// Short item queue between the front and back parts.
// Depends on pcc_pkg.
module pcc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pcc_pkg::t_item o_item
);
    import pcc_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: hdl/pcc_front.sv
// Front part: accepts bytes, tracks frame and block position, builds queue items.
// Depends on pcc_pkg.
module pcc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic [31:0]    i_frame_address,
    input  logic           i_direction,
    input  logic [31:0]    i_frame_counter,
    output pcc_pkg::t_item o_item
);
    import pcc_pkg::*;

    logic        r_in_frame;
    logic [3:0]  r_pos;
    logic [7:0]  r_cnt;
    logic [31:0] r_addr;
    logic        r_dir;
    logic [31:0] r_fcnt;
    logic [3:0]  pos;
    logic [7:0]  cnt;
    logic [12:0] done;
    logic        fin;

    always_comb begin
        pos  = r_in_frame ? r_pos : 4'd0;
        cnt  = r_in_frame ? r_cnt : 8'd1;
        done = {1'b0, cnt - 8'd1, pos} + 13'd1;
        fin  = i_last_byte || (done >= 13'(MAX_FRAME_BYTES));
        o_item.data      = i_data_byte;
        o_item.last      = fin;
        o_item.pos       = pos;
        o_item.cnt       = cnt;
        o_item.frm_start = !r_in_frame;
        o_item.blk_start = (pos == 4'd0);
        o_item.addr      = r_in_frame ? r_addr : i_frame_address;
        o_item.dir       = r_in_frame ? r_dir  : i_direction;
        o_item.fcnt      = r_in_frame ? r_fcnt : i_frame_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_cnt      <= 8'd1;
            r_addr     <= '0;
            r_dir      <= 1'b0;
            r_fcnt     <= '0;
        end else if (i_acc) begin
            r_in_frame <= !fin;
            r_pos      <= pos + 4'd1;
            r_cnt      <= (pos == 4'd15) ? cnt + 8'd1 : cnt;
            r_addr     <= o_item.addr;
            r_dir      <= o_item.dir;
            r_fcnt     <= o_item.fcnt;
        end
    end
endmodule

// File: hdl/pcc_aes.sv
// Iterative AES-128 encryption core, one round per cycle with on-the-fly key expansion.
// Depends on pcc_pkg.
module pcc_aes (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    input  logic [127:0] i_block,
    output logic         o_busy,
    output logic         o_fin,
    output logic [127:0] o_res
);
    import pcc_pkg::*;

    logic [127:0] r_st;
    logic [127:0] r_rk;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic         r_busy;
    logic         r_fin;
    logic [127:0] rk_nx;
    logic [127:0] sb;
    logic [127:0] mx;
    logic [31:0]  kt;
    logic [7:0]   a0, a1, a2, a3, al;

    always_comb begin
        kt = {SBOX[r_rk[103:96]], SBOX[r_rk[127:120]], SBOX[r_rk[119:112]],
              SBOX[r_rk[111:104]] ^ r_rc};
        rk_nx[31:0]   = r_rk[31:0]   ^ kt;
        rk_nx[63:32]  = r_rk[63:32]  ^ rk_nx[31:0];
        rk_nx[95:64]  = r_rk[95:64]  ^ rk_nx[63:32];
        rk_nx[127:96] = r_rk[127:96] ^ rk_nx[95:64];
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sb[8*(i+4*c) +: 8] = SBOX[r_st[8*(i + 4*((c+i) % 4)) +: 8]];
            end
        end
        mx = sb;
        for (int c = 0; c < 4; c++) begin
            a0 = sb[32*c +: 8];
            a1 = sb[32*c+8 +: 8];
            a2 = sb[32*c+16 +: 8];
            a3 = sb[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (r_rnd != 4'(AES_ROUNDS)) begin
                mx[32*c +: 8]    = a0 ^ al ^ xt(a0 ^ a1);
                mx[32*c+8 +: 8]  = a1 ^ al ^ xt(a1 ^ a2);
                mx[32*c+16 +: 8] = a2 ^ al ^ xt(a2 ^ a3);
                mx[32*c+24 +: 8] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_fin  = r_fin;
    assign o_res  = r_st;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_st <= i_block ^ i_key;
            r_rk <= i_key;
            r_rc <= RCON_ONE;
        end else if (r_busy) begin
            r_st <= mx ^ rk_nx;
            r_rk <= rk_nx;
            r_rc <= xt(r_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_fin <= r_busy && (r_rnd == 4'(AES_ROUNDS));
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= 4'd1;
            end else if (r_busy) begin
                r_busy <= (r_rnd != 4'(AES_ROUNDS));
                r_rnd  <= r_rnd + 4'd1;
            end
        end
    end
endmodule

// File: hdl/pcc_back.sv
// Back part: produces keystream blocks (prefetching the next one) and XORs queued bytes.
// Depends on pcc_pkg and pcc_aes.
module pcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [127:0]   i_key,
    input  logic           i_key_wr,
    input  logic           i_empty,
    input  pcc_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);
    import pcc_pkg::*;

    logic [127:0] r_ks;
    logic         r_done;
    logic         r_dem;
    logic         r_stale;
    logic         r_ov;
    logic [7:0]   r_ob;
    logic         r_ol;
    logic         busy, fin, rdy, usable, consume, start, start_dem;
    logic [127:0] res, blk, ks;
    logic [7:0]   bcnt;

    pcc_aes u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_key   (i_key),
        .i_block (blk),
        .o_busy  (busy),
        .o_fin   (fin),
        .o_res   (res)
    );

    always_comb begin
        rdy       = (r_done || fin) && !r_stale;
        usable    = rdy && (r_dem == i_item.frm_start);
        o_pop     = !i_empty && (!i_item.blk_start || usable) && (!r_ov || !i_stall);
        consume   = o_pop && i_item.blk_start;
        start_dem = !i_empty && i_item.blk_start && !usable && !busy;
        start     = consume || start_dem;
        bcnt      = consume ? i_item.cnt + 8'd1 : i_item.cnt;
        blk       = '0;
        blk[7:0]     = CTR_TAG;
        blk[40]      = i_item.dir;
        blk[79:48]   = i_item.addr;
        blk[111:80]  = i_item.fcnt;
        blk[127:120] = bcnt;
        ks        = i_item.blk_start ? res : r_ks;
    end

    assign o_valid    = r_ov;
    assign o_out_byte = r_ob;
    assign o_out_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (consume) r_ks <= res;
        if (o_pop) begin
            r_ob <= i_item.data ^ ks[8*i_item.pos +: 8];
            r_ol <= i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_dem   <= 1'b0;
            r_stale <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_done <= rdy && !start;
            if (start) r_dem <= start_dem && i_item.frm_start;
            if (i_key_wr) begin
                r_stale <= 1'b1;
            end else if (start) begin
                r_stale <= 1'b0;
            end
            if (o_pop) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

// File: hdl/payload_ctr_cipher.sv
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_data_byte i_last_byte i_frame_address i_direction i_frame_counter
// output    o_valid   i_stall   o_out_byte o_out_last
// One byte per cycle within a frame unless stalled or waiting for keystream; the iterative
// AES core computes the next block while the current 16 bytes stream out.
// A frame's first byte reaches the result register once its keystream block is computed, and
// waits longer while the previous frame's prefetch finishes.
// A key write drops the prefetched block; the next block is computed again.
// Reset is synchronous, active low; the key registers reset to zero.
// Input stalls only when the 4-entry queue is full; output stall holds the result register.
// Top level; depends on pcc_pkg, pcc_front, pcc_fifo, pcc_back.
module payload_ctr_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_frame_address,
    input  logic        i_direction,
    input  logic [31:0] i_frame_counter,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import pcc_pkg::*;

    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    logic        full, empty, pop, acc;
    t_item       f_item, q_item;

    assign o_stall = full;
    assign acc     = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_LOW:  r_key_lo <= i_cfg_data;
                CFG_KEY_HIGH: r_key_hi <= i_cfg_data;
                default:      r_key_lo <= r_key_lo;
            endcase
        end
    end

    pcc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_acc           (acc),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_frame_address (i_frame_address),
        .i_direction     (i_direction),
        .i_frame_counter (i_frame_counter),
        .o_item          (f_item)
    );

    pcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    pcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      ({r_key_hi, r_key_lo}),
        .i_key_wr   (i_cfg_we),
        .i_empty    (empty),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );
endmodule

// File: tb/tb.sv
// Testbench for payload_ctr_cipher: drives payload bytes through the cipher and checks each
// result against an in-bench AES-128 CTR predictor, under several keys and idling patterns.
// Depends on pcc_pkg and the payload_ctr_cipher RTL.
module tb;
    import pcc_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] addr;
        logic        dir;
        logic [31:0] fcnt;
        logic        exp_last;
    } t_row;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_cipher_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic [31:0] i_frame_address;
    logic        i_direction;
    logic [31:0] i_frame_counter;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;

    payload_ctr_cipher dut (.*);

    always #2 i_clk = ~i_clk;

    logic [63:0]  key_lo, key_hi;
    logic [7:0]   blk_num;
    logic [3:0]   byte_pos;
    logic [127:0] keystream;
    logic         frame_open;
    logic [31:0]  frm_addr, frm_fcnt;
    logic         frm_dir;

    t_cipher_out  cipher_q[$];
    int           errors;
    int           idle_pct;
    int           stall_pct;

    function automatic logic [7:0] gmul2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] block_cipher(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] rc, w0, w1, w2, w3, tmp, a0, a1, a2, a3, all;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
        for (int i = 16; i < 176; i += 4) begin
            w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
            if ((i % 16) == 0) begin
                tmp = w0;
                w0 = SBOX[w1] ^ rc;
                w1 = SBOX[w2];
                w2 = SBOX[w3];
                w3 = SBOX[tmp];
                rc = gmul2(rc);
            end
            rk[i]   = rk[i-16] ^ w0;
            rk[i+1] = rk[i-15] ^ w1;
            rk[i+2] = rk[i-14] ^ w2;
            rk[i+3] = rk[i-13] ^ w3;
        end
        for (int i = 0; i < 16; i++) s[i] = pt[8*i +: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i + 4*c] = SBOX[s[i + 4*((c + i) % 4)]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
        end
        for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
        return res;
    endfunction

    task automatic predict_cipher(input t_row it, input logic use_typed);
        logic [127:0] ctr_blk;
        logic [31:0]  done;
        t_cipher_out  o;
        if (!frame_open) begin
            frm_addr = it.addr;
            frm_dir = it.dir;
            frm_fcnt = it.fcnt;
            blk_num = 8'd1;
            byte_pos = 4'd0;
            frame_open = 1'b1;
        end
        if (byte_pos == 4'd0) begin
            ctr_blk = '0;
            ctr_blk[7:0] = CTR_TAG;
            ctr_blk[47:40] = {7'd0, frm_dir};
            ctr_blk[79:48] = frm_addr;
            ctr_blk[111:80] = frm_fcnt;
            ctr_blk[127:120] = blk_num;
            keystream = block_cipher({key_hi, key_lo}, ctr_blk);
        end
        o.data = it.data ^ keystream[8*byte_pos +: 8];
        done = (32'(blk_num) - 1) * 16 + 32'(byte_pos) + 1;
        o.last = it.last || (done >= MAX_FRAME_BYTES);
        if (o.last) frame_open = 1'b0;
        if (use_typed) o.last = it.exp_last;
        cipher_q.push_back(o);
        byte_pos = byte_pos + 4'd1;
        if (byte_pos == 4'd0) blk_num = blk_num + 8'd1;
    endtask

    task automatic send_byte(input t_row it, input logic use_typed);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= it.data;
        i_last_byte <= it.last;
        i_frame_address <= it.addr;
        i_direction <= it.dir;
        i_frame_counter <= it.fcnt;
        do @(posedge i_clk); while (o_stall);
        predict_cipher(it, use_typed);
    endtask

    task automatic drain_and_set_key(input logic [63:0] lo, input logic [63:0] hi);
        i_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx <= CFG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_lo = lo;
        key_hi = hi;
    endtask

    task automatic random_frames(input int budget);
        t_row it;
        int   len, kind, sent;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(99);
            if (kind < 70) len = $urandom_range(1, 40);
            else if (kind < 90) len = $urandom_range(41, 255);
            else len = $urandom_range(256, 270);
            for (int n = 0; n < len; n++) begin
                it.data = 8'($urandom);
                it.addr = $urandom;
                it.dir = 1'($urandom);
                it.fcnt = $urandom;
                it.last = (kind >= 90) ? 1'b0 : (n == len - 1);
                if ($urandom_range(99) < 3) it.last = 1'($urandom);
                it.exp_last = 1'b0;
                send_byte(it, 1'b0);
                sent++;
            end
        end
    endtask

    t_row directed_rows [19] = '{
        '{8'h00, 1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1},
        '{8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{8'h00, 1'b0, 32'h1234_5678, 1'b0, 32'h0000_0001, 1'b0},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{8'h55, 1'b0, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 1'b0},
        '{8'hAA, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{8'h01, 1'b0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
        '{8'h80, 1'b0, 32'h0000_0001, 1'b0, 32'h0000_0001, 1'b0},
        '{8'h0F, 1'b0, 32'hDEAD_BEEF, 1'b1, 32'hCAFE_F00D, 1'b0},
        '{8'hF0, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{8'h3C, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{8'hC3, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{8'h12, 1'b0, 32'h1111_1111, 1'b1, 32'h2222_2222, 1'b0},
        '{8'h34, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{8'h56, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{8'h78, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0},
        '{8'h9A, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{8'hBC, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0},
        '{8'hDE, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1}
    };

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_cipher_out exp_out;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected result byte %h last %b", $time, o_out_byte,
                         o_out_last);
                errors++;
            end else begin
                exp_out = cipher_q.pop_front();
                if (o_out_byte !== exp_out.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, exp_out.data,
                             o_out_byte);
                    errors++;
                end
                if (o_out_last !== exp_out.last) begin
                    $display("%0t: out_last expected %b actual %b", $time, exp_out.last,
                             o_out_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("FAIL payload_ctr_cipher");
        $finish;
    end

    initial begin
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        key_lo = '0;
        key_hi = '0;
        blk_num = 8'd1;
        byte_pos = 4'd0;
        keystream = '0;
        frame_open = 1'b0;
        frm_addr = '0;
        frm_dir = 1'b0;
        frm_fcnt = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        i_frame_address <= '0;
        i_direction <= 1'b0;
        i_frame_counter <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_KEY_LOW;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) send_byte(directed_rows[k], 1'b1);

        drain_and_set_key('1, '1);
        foreach (directed_rows[k]) send_byte(directed_rows[k], 1'b0);
        random_frames(250);

        drain_and_set_key(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
        idle_pct = 50;
        random_frames(300);

        drain_and_set_key('0, {$urandom, $urandom});
        idle_pct = 0;
        stall_pct = 50;
        random_frames(300);

        drain_and_set_key({$urandom, $urandom}, '0);
        idle_pct = 7;
        stall_pct = 7;
        random_frames(300);

        drain_and_set_key({$urandom, $urandom}, {$urandom, $urandom});
        idle_pct = 0;
        stall_pct = 0;
        random_frames(300);

        drain_and_set_key({$urandom, $urandom}, {$urandom, $urandom});
        idle_pct = 50;
        stall_pct = 50;
        random_frames(300);

        i_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("PASS payload_ctr_cipher");
        else
            $display("FAIL payload_ctr_cipher");
        $finish;
    end
endmodule

// File: sim.f
hdl/pcc_pkg.sv
hdl/pcc_fifo.sv
hdl/pcc_front.sv
hdl/pcc_aes.sv
hdl/pcc_back.sv
hdl/payload_ctr_cipher.sv
tb/tb.sv
